[design/btn_dbc_pkg.sv]
`timescale 1ns / 1ps
// btn_dbc_pkg: types and constants shared by the button debounce lanes,
// the merge stage and the top level. No dependencies.
package btn_dbc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int DEB_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd20;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef enum logic [0:0] {
        REG_DEBOUNCE_TICKS   = 1'b0,
        REG_LONG_PRESS_TICKS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pin_levels;
        logic                   tick;
        logic [NUM_BUTTONS-1:0] clear_click_mask;
        logic [NUM_BUTTONS-1:0] clear_long_mask;
    } t_in_item;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pressed_mask;
        logic [NUM_BUTTONS-1:0] click_pending;
        logic [NUM_BUTTONS-1:0] long_pending;
    } t_out_item;

    typedef struct packed {
        logic fire;
        logic tick;
        logic pin;
        logic clr_click;
        logic clr_long;
    } t_lane_cmd;

    typedef struct packed {
        logic pressed;
        logic click;
        logic long_evt;
    } t_lane_status;

endpackage

[design/btn_dbc_lane.sv]
`timescale 1ns / 1ps
// btn_dbc_lane: debounce, click and long-press state of one button.
// Depends on btn_dbc_pkg.
module btn_dbc_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  btn_dbc_pkg::t_lane_cmd              i_cmd,
    input  logic [btn_dbc_pkg::DEB_W-1:0]       i_debounce_ticks,
    input  logic [btn_dbc_pkg::HOLD_W-1:0]      i_long_press_ticks,
    output btn_dbc_pkg::t_lane_status           o_status
);

    logic                           r_last_raw,  n_last_raw;
    logic                           r_confirmed, n_confirmed;
    logic [btn_dbc_pkg::DEB_W-1:0]  r_settle,    n_settle;
    logic [btn_dbc_pkg::HOLD_W-1:0] r_hold,      n_hold;
    logic                           r_long_seen, n_long_seen;
    logic                           r_click,     n_click;
    logic                           r_long,      n_long;

    always_comb begin
        logic now_pressed;
        now_pressed = ~i_cmd.pin;
        n_last_raw  = r_last_raw;
        n_confirmed = r_confirmed;
        n_settle    = r_settle;
        n_hold      = r_hold;
        n_long_seen = r_long_seen;
        n_click     = r_click & ~i_cmd.clr_click;
        n_long      = r_long & ~i_cmd.clr_long;
        if (i_cmd.tick) begin
            if (now_pressed != r_last_raw) begin
                n_last_raw = now_pressed;
                n_settle   = (i_debounce_ticks == '0) ? btn_dbc_pkg::DEB_W'(1)
                                                      : i_debounce_ticks;
            end
            if (n_settle != '0) begin
                n_settle = n_settle - btn_dbc_pkg::DEB_W'(1);
                if (n_settle == '0 && r_confirmed != n_last_raw) begin
                    n_confirmed = n_last_raw;
                    if (n_last_raw) begin
                        n_hold      = '0;
                        n_long_seen = 1'b0;
                    end else if (!r_long_seen) begin
                        n_click = 1'b1;
                    end
                end
            end
            if (n_confirmed && n_hold < i_long_press_ticks) begin
                n_hold = n_hold + btn_dbc_pkg::HOLD_W'(1);
                if (n_hold == i_long_press_ticks) begin
                    n_long_seen = 1'b1;
                    n_long      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_confirmed <= 1'b0;
            r_settle    <= '0;
            r_hold      <= '0;
            r_long_seen <= 1'b0;
            r_click     <= 1'b0;
            r_long      <= 1'b0;
        end else if (i_cmd.fire) begin
            r_last_raw  <= n_last_raw;
            r_confirmed <= n_confirmed;
            r_settle    <= n_settle;
            r_hold      <= n_hold;
            r_long_seen <= n_long_seen;
            r_click     <= n_click;
            r_long      <= n_long;
        end
    end

    // result of this transfer, valid in the cycle of acceptance
    assign o_status.pressed  = n_confirmed;
    assign o_status.click    = n_click;
    assign o_status.long_evt = n_long;

endmodule

[design/btn_dbc_merge.sv]
`timescale 1ns / 1ps
// btn_dbc_merge: gathers the lane results into one result item and holds it
// in an output register with a skid stage. Depends on btn_dbc_pkg.
module btn_dbc_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_in_fire,
    input  btn_dbc_pkg::t_lane_status i_lanes [btn_dbc_pkg::NUM_BUTTONS],
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output btn_dbc_pkg::t_out_item    o_out_data
);

    btn_dbc_pkg::t_out_item w_item;
    btn_dbc_pkg::t_out_item r_out_data, r_skid_data;
    logic                   r_out_valid, r_skid_valid;
    logic                   w_out_fire;

    always_comb begin
        for (int k = 0; k < btn_dbc_pkg::NUM_BUTTONS; k++) begin
            w_item.pressed_mask[k]  = i_lanes[k].pressed;
            w_item.click_pending[k] = i_lanes[k].click;
            w_item.long_pending[k]  = i_lanes[k].long_evt;
        end
    end

    assign o_in_stall = r_skid_valid;
    assign o_in_fire  = i_in_valid & ~r_skid_valid;
    assign w_out_fire = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (o_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (o_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_data <= w_item;
            end else begin
                r_skid_data <= w_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[design/button_debounce_click_long_press_unit.sv]
`timescale 1ns / 1ps
// Debounced buttons with click and long-press latches: one lane per button
// updates in the cycle an item is accepted, and the merge stage registers the
// result. An item is accepted every clock while the input is not stalled; the
// result goes to the output register, and a skid stage lets one more item in
// while a result waits, so the input stalls only when both hold an item. Registers
// (APB): debounce_ticks at 0x0, long_press_ticks at 0x4.
// Depends on btn_dbc_pkg, btn_dbc_lane and btn_dbc_merge.
module button_debounce_click_long_press_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  btn_dbc_pkg::t_in_item                   i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output btn_dbc_pkg::t_out_item                  o_out_data,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [btn_dbc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [btn_dbc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [btn_dbc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                    pready
);

    logic [btn_dbc_pkg::DEB_W-1:0]  r_debounce_ticks;
    logic [btn_dbc_pkg::HOLD_W-1:0] r_long_press_ticks;
    logic                           w_wr;
    btn_dbc_pkg::t_reg_idx          w_idx;
    logic                           w_in_fire;
    btn_dbc_pkg::t_lane_status      w_lanes [btn_dbc_pkg::NUM_BUTTONS];

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = btn_dbc_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= btn_dbc_pkg::DEBOUNCE_RESET;
            r_long_press_ticks <= btn_dbc_pkg::LONG_PRESS_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                btn_dbc_pkg::REG_DEBOUNCE_TICKS:
                    r_debounce_ticks <= pwdata[btn_dbc_pkg::DEB_W-1:0];
                btn_dbc_pkg::REG_LONG_PRESS_TICKS:
                    r_long_press_ticks <= pwdata[btn_dbc_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            btn_dbc_pkg::REG_DEBOUNCE_TICKS:
                prdata = btn_dbc_pkg::APB_DATA_W'(r_debounce_ticks);
            btn_dbc_pkg::REG_LONG_PRESS_TICKS:
                prdata = btn_dbc_pkg::APB_DATA_W'(r_long_press_ticks);
            default:
                prdata = '0;
        endcase
    end

    for (genvar k = 0; k < btn_dbc_pkg::NUM_BUTTONS; k++) begin : g_lane
        btn_dbc_pkg::t_lane_cmd w_cmd;
        assign w_cmd.fire      = w_in_fire;
        assign w_cmd.tick      = i_in_data.tick;
        assign w_cmd.pin       = i_in_data.pin_levels[k];
        assign w_cmd.clr_click = i_in_data.clear_click_mask[k];
        assign w_cmd.clr_long  = i_in_data.clear_long_mask[k];

        btn_dbc_lane u_lane (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_cmd              (w_cmd),
            .i_debounce_ticks   (r_debounce_ticks),
            .i_long_press_ticks (r_long_press_ticks),
            .o_status           (w_lanes[k])
        );
    end

    btn_dbc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_in_fire   (w_in_fire),
        .i_lanes     (w_lanes),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
